### hdl/bounded_min_max_heap_macros.svh
// Assertion macros for the bounded min-max heap.
// Each expects clk and arst_n in the scope of use.
`ifndef BOUNDED_MIN_MAX_HEAP_MACROS_SVH
`define BOUNDED_MIN_MAX_HEAP_MACROS_SVH

// Condition holds at every clock edge out of reset
`define BMMH_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define BMMH_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define BMMH_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/bmmh_pkg.sv
// Shared types, codes and helpers of the bounded min-max heap.
// No dependencies.
package bmmh_pkg;

	localparam int KEY_W     = 32;
	localparam int TAG_W     = 16;
	localparam int CNT_W     = 9;
	localparam int LVL_W     = 17;
	localparam int DEPTH_DEF = 256;

	localparam logic [CNT_W-1:0] BOUND_RESET = 9'd256;

	localparam logic [1:0] KIND_INSERT = 2'd0;

	localparam logic [2:0] OUT_INSERTED = 3'd0;
	localparam logic [2:0] OUT_EVICTED  = 3'd1;
	localparam logic [2:0] OUT_REJECTED = 3'd2;
	localparam logic [2:0] OUT_POPPED   = 3'd3;
	localparam logic [2:0] OUT_EMPTY    = 3'd4;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       outcome;
		logic [KEY_W-1:0] out_key;
		logic [TAG_W-1:0] out_tag;
		logic [CNT_W-1:0] entry_count;
		logic [KEY_W-1:0] least_key;
		logic [KEY_W-1:0] greatest_key;
	} out_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	// Strict order: less on min levels, greater on max levels
	function automatic logic key_before(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
			logic want_min);
		return want_min ? (a < b) : (a > b);
	endfunction

	// Slot index sits on a min level when its tree depth is even
	function automatic logic on_min_level(logic [LVL_W-1:0] n);
		logic odd;
		odd = 1'b0;
		for (int b = 0; b < LVL_W; b++) begin
			if (n[b]) odd = b[0];
		end
		return !odd;
	endfunction

endpackage

### hdl/bounded_min_max_heap.sv
// Bounded min-max heap top level: bound register and the sequencer.
// Depends on bmmh_pkg and bmmh_ctrl.
//
// Use: items enter on in_valid/in_ready (insert, pop minimum, pop maximum)
// and each gives one result item on out_valid/out_ready with the outcome,
// the popped, evicted or rejected entry, the count and the extreme keys.
// cfg_we/cfg_wdata write the bound; the user must write it only while the
// block is idle, and the block itself does not enforce that. Unless the
// heap is empty, an insert compares the new entry with its parent and then
// climbs it grandparent by grandparent. A pop takes the entry, moves the last
// entry into its slot and sifts it down; each sift-down step reads the
// children and grandchildren present through the single read port, then makes
// a decision and an optional parent write. An evicting insert pops the minimum
// before it inserts. Every path ends with reads of the root and max-level
// slots and the result step. One item is worked on at a time; the next can be
// taken once the result is loaded into the output register, even while it
// still waits. Reset clears the count to empty and the bound to 256; the
// entry memory is not cleared. A stalled receiver holds the result and, once
// the next item is done, holds the sequencer too.
module bounded_min_max_heap import bmmh_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item
);

	logic [CNT_W-1:0] bound_q;

	// Hold the bound register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= BOUND_RESET;
		end else if (cfg_we) begin
			bound_q <= cfg_wdata;
		end
	end

	bmmh_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.bound     (bound_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

### hdl/bmmh_store.sv
// Entry memory of the heap: one write port, one registered read port.
// Depends on bmmh_pkg for the entry type.
module bmmh_store import bmmh_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [0:DEPTH];

	// Write, and forward a write to the slot read in the same cycle
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/bmmh_ctrl.sv
// Sequencer of the heap: insert, evict and pop walks over the entry memory,
// plus the result register. Depends on bmmh_pkg, bmmh_store and the macro header.
`include "bounded_min_max_heap_macros.svh"
module bmmh_ctrl import bmmh_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] bound,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item
);

	localparam int AW = $clog2(DEPTH + 1);
	localparam int XW = AW + 2;

	localparam logic [4:0] S_IDLE = 5'd0,  S_FULLCHK = 5'd1,  S_PMAX2 = 5'd2,
		S_PMAX3 = 5'd3,  S_TAKE_RD = 5'd4,  S_TAKE_LAST = 5'd5,  S_AFTER = 5'd6,
		S_SD_RD = 5'd7,  S_SD_CMP = 5'd8,  S_SD_DEC = 5'd9,  S_SD_PW = 5'd10,
		S_SD_WB = 5'd11, S_INS = 5'd12,  S_SU_P = 5'd13,  S_CL_RD = 5'd14,
		S_CL_CMP = 5'd15, S_FIN0 = 5'd16, S_FIN1 = 5'd17, S_FIN2 = 5'd18,
		S_FIN3 = 5'd19,  S_DONE = 5'd20;

	logic [4:0]       state_q;
	logic [AW-1:0]    cnt_q, i_q, best_q;
	logic [XW-1:0]    x_q;
	logic [2:0]       cand_q, outcome_q;
	logic             best_ok_q, ins_after_q, want_min_q, out_valid_q;
	entry_t           cur_q, new_q, best_e_q, ch0_q, ch1_q, res_q, k2e_q;
	logic [KEY_W-1:0] k1_q, k2_q, lk_q, gk_q;
	out_item_t        out_item_q;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	entry_t           mem_wdata, rdata;

	logic [AW-1:0]    eff, cnt_m1, cnt_p1;
	logic [XW-1:0]    a_x, x_c;
	logic             accept, out_load;
	entry_t           pe;

	bmmh_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// Effective bound, count steps and sift-down candidate slot
	always_comb begin
		eff    = (bound < 9'd2 || 32'(bound) > DEPTH) ? AW'(DEPTH) : AW'(bound);
		cnt_m1 = cnt_q - AW'(1);
		cnt_p1 = cnt_q + AW'(1);
		a_x    = XW'(i_q) << 1;
		x_c    = (cand_q < 3'd2) ? a_x + XW'(cand_q) : (XW'(i_q) << 2) + XW'(cand_q - 3'd2);
		pe     = best_q[1] ? ch1_q : ch0_q;
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Memory requests of each step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = cur_q;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (in_item.kind == KIND_INSERT) begin
					mem_raddr = AW'(1);
				end else if (!in_item.kind[1]) begin
					mem_raddr = AW'(1);
				end else if (cnt_q <= AW'(2)) begin
					mem_raddr = cnt_q;
				end else begin
					mem_raddr = AW'(2);
				end
			end
			S_FULLCHK, S_PMAX3, S_TAKE_RD: mem_raddr = cnt_q;
			S_PMAX2: mem_raddr = AW'(3);
			S_SD_RD: mem_raddr = AW'(x_c);
			S_SD_DEC: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				if (best_ok_q && key_before(best_e_q.key, cur_q.key, want_min_q)) begin
					mem_wdata = best_e_q;
				end
			end
			S_SD_PW: begin
				mem_we    = 1'b1;
				mem_waddr = best_q >> 1;
			end
			S_SD_WB: begin
				mem_we    = 1'b1;
				mem_waddr = best_q;
			end
			S_INS: begin
				if (cnt_p1 == AW'(1)) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(1);
					mem_wdata = new_q;
				end else begin
					mem_raddr = cnt_p1 >> 1;
				end
			end
			S_SU_P: begin
				mem_raddr = AW'(0);
				if (want_min_q ? (cur_q.key > rdata.key) : (cur_q.key < rdata.key)) begin
					mem_we    = 1'b1;
					mem_waddr = i_q;
					mem_wdata = rdata;
				end
			end
			S_CL_RD: begin
				if ((i_q >> 2) == '0) begin
					mem_we    = 1'b1;
					mem_waddr = i_q;
				end else begin
					mem_raddr = i_q >> 2;
				end
			end
			S_CL_CMP: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				if (key_before(cur_q.key, rdata.key, want_min_q)) mem_wdata = rdata;
			end
			S_FIN0: mem_raddr = AW'(1);
			S_FIN1: mem_raddr = AW'(2);
			S_FIN2: mem_raddr = AW'(3);
			default: mem_raddr = '0;
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			best_ok_q   <= 1'b0;
			ins_after_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						new_q       <= '{key: in_item.key, tag: in_item.tag};
						res_q       <= '0;
						ins_after_q <= 1'b0;
						if (in_item.kind == KIND_INSERT) begin
							outcome_q <= OUT_INSERTED;
							state_q   <= (cnt_q >= eff) ? S_FULLCHK : S_INS;
						end else if (cnt_q == '0) begin
							outcome_q <= OUT_EMPTY;
							state_q   <= S_FIN0;
						end else begin
							outcome_q <= OUT_POPPED;
							if (!in_item.kind[1]) begin
								i_q     <= AW'(1);
								state_q <= S_TAKE_RD;
							end else if (cnt_q <= AW'(2)) begin
								i_q     <= cnt_q;
								state_q <= S_TAKE_RD;
							end else begin
								state_q <= S_PMAX2;
							end
						end
					end
				end
				S_FULLCHK: begin
					if (rdata.key > new_q.key) begin
						outcome_q <= OUT_REJECTED;
						res_q     <= new_q;
						state_q   <= S_FIN0;
					end else begin
						outcome_q   <= OUT_EVICTED;
						res_q       <= rdata;
						i_q         <= AW'(1);
						ins_after_q <= 1'b1;
						state_q     <= S_TAKE_LAST;
					end
				end
				S_PMAX2: begin
					k2e_q   <= rdata;
					state_q <= S_PMAX3;
				end
				S_PMAX3: begin
					if (k2e_q.key < rdata.key) begin
						i_q   <= AW'(3);
						res_q <= rdata;
					end else begin
						i_q   <= AW'(2);
						res_q <= k2e_q;
					end
					state_q <= S_TAKE_LAST;
				end
				S_TAKE_RD: begin
					res_q   <= rdata;
					state_q <= S_TAKE_LAST;
				end
				S_TAKE_LAST: begin
					cur_q <= rdata;
					cnt_q <= cnt_m1;
					if (i_q <= cnt_m1) begin
						want_min_q <= on_min_level(LVL_W'(i_q));
						cand_q     <= '0;
						best_ok_q  <= 1'b0;
						state_q    <= S_SD_RD;
					end else begin
						state_q <= S_AFTER;
					end
				end
				S_AFTER: state_q <= ins_after_q ? S_INS : S_FIN0;
				S_SD_RD: begin
					x_q     <= x_c;
					state_q <= (x_c <= XW'(cnt_q)) ? S_SD_CMP : S_SD_DEC;
				end
				S_SD_CMP: begin
					if (cand_q == 3'd0) ch0_q <= rdata;
					if (cand_q == 3'd1) ch1_q <= rdata;
					if (!best_ok_q || key_before(rdata.key, best_e_q.key, want_min_q)) begin
						best_ok_q <= 1'b1;
						best_q    <= AW'(x_q);
						best_e_q  <= rdata;
					end
					cand_q  <= cand_q + 3'd1;
					state_q <= (cand_q == 3'd5) ? S_SD_DEC : S_SD_RD;
				end
				S_SD_DEC: begin
					if (!best_ok_q || !key_before(best_e_q.key, cur_q.key, want_min_q)) begin
						state_q <= S_AFTER;
					end else if (XW'(best_q) <= a_x + XW'(1)) begin
						state_q <= S_SD_WB;
					end else if (!key_before(cur_q.key, pe.key, want_min_q)) begin
						state_q <= S_SD_PW;
					end else begin
						i_q       <= best_q;
						cand_q    <= '0;
						best_ok_q <= 1'b0;
						state_q   <= S_SD_RD;
					end
				end
				S_SD_PW: begin
					cur_q     <= pe;
					i_q       <= best_q;
					cand_q    <= '0;
					best_ok_q <= 1'b0;
					state_q   <= S_SD_RD;
				end
				S_SD_WB: state_q <= S_AFTER;
				S_INS: begin
					cnt_q      <= cnt_p1;
					i_q        <= cnt_p1;
					cur_q      <= new_q;
					want_min_q <= on_min_level(LVL_W'(cnt_p1));
					state_q    <= (cnt_p1 == AW'(1)) ? S_FIN0 : S_SU_P;
				end
				S_SU_P: begin
					if (want_min_q ? (cur_q.key > rdata.key) : (cur_q.key < rdata.key)) begin
						i_q        <= i_q >> 1;
						want_min_q <= !want_min_q;
					end
					state_q <= S_CL_RD;
				end
				S_CL_RD: state_q <= ((i_q >> 2) == '0) ? S_FIN0 : S_CL_CMP;
				S_CL_CMP: begin
					if (key_before(cur_q.key, rdata.key, want_min_q)) begin
						i_q     <= i_q >> 2;
						state_q <= S_CL_RD;
					end else begin
						state_q <= S_FIN0;
					end
				end
				S_FIN0: state_q <= S_FIN1;
				S_FIN1: begin
					k1_q    <= rdata.key;
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					k2_q    <= rdata.key;
					state_q <= S_FIN3;
				end
				S_FIN3: begin
					lk_q <= (cnt_q == '0) ? '0 : k1_q;
					if (cnt_q == '0) begin
						gk_q <= '0;
					end else if (cnt_q == AW'(1)) begin
						gk_q <= k1_q;
					end else if (cnt_q == AW'(2)) begin
						gk_q <= k2_q;
					end else begin
						gk_q <= (k2_q > rdata.key) ? k2_q : rdata.key;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the result item until taken
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q <= '{outcome: outcome_q, out_key: res_q.key, out_tag: res_q.tag,
				entry_count: CNT_W'(cnt_q), least_key: lk_q, greatest_key: gk_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`BMMH_CHECK(a_cnt_in_range, 32'(cnt_q) <= DEPTH, "entry count above depth")
	`BMMH_IMPLIES(a_ins_room, state_q == S_INS, 32'(cnt_q) < DEPTH, "insert with no room")
	`BMMH_NEXT(a_empty_zero, out_load && outcome_q == OUT_EMPTY, out_item.entry_count == '0,
		"empty pop with nonzero count")

endmodule

### tb/bounded_min_max_heap_test.sv
// Self-checking bench for the bounded min-max heap: predicts each result with its own
// heap copy in a small scoreboard class and drives random, stalled traffic.
// Depends on bmmh_pkg and the bounded_min_max_heap top level.
module bounded_min_max_heap_test;
	import bmmh_pkg::*;

	localparam logic [1:0] KIND_POP_MIN = 2'd1;
	localparam logic [1:0] KIND_POP_MAX = 2'd2;
	localparam logic [1:0] KIND_ALT_MAX = 2'd3;
	localparam int         HEAP_SLOTS   = DEPTH_DEF;

	// Expected-result store with its own copy of the heap
	class heap_scoreboard;
		logic [KEY_W-1:0] keys[0:HEAP_SLOTS];
		logic [TAG_W-1:0] tags[0:HEAP_SLOTS];
		int unsigned      held;
		int unsigned      bound_reg;
		out_item_t        pending[$];
		int unsigned      mismatches;
		int unsigned      results_seen;
		int unsigned      evictions;
		int unsigned      rejections;
		int unsigned      max_held;

		function new();
			held = 0;
			bound_reg = 256;
			mismatches = 0;
			results_seen = 0;
			evictions = 0;
			rejections = 0;
			max_held = 0;
		endfunction

		function void set_bound(logic [CNT_W-1:0] v);
			bound_reg = v;
		endfunction

		function bit ahead(int unsigned i, int unsigned j, bit want_min);
			return want_min ? (keys[i] < keys[j]) : (keys[i] > keys[j]);
		endfunction

		function void swap_pair(int unsigned i, int unsigned j);
			logic [KEY_W-1:0] k;
			logic [TAG_W-1:0] t;
			k = keys[i]; t = tags[i];
			keys[i] = keys[j]; tags[i] = tags[j];
			keys[j] = k; tags[j] = t;
		endfunction

		function bit min_row(int unsigned n);
			int unsigned d;
			d = 0;
			while (n > 1) begin
				n = n >> 1;
				d++;
			end
			return d[0] == 1'b0;
		endfunction

		function void climb(int unsigned i, bit want_min);
			while (i / 4 > 0 && ahead(i, i / 4, want_min)) begin
				swap_pair(i, i / 4);
				i = i / 4;
			end
		endfunction

		function void raise_slot(int unsigned i);
			int unsigned p;
			p = i / 2;
			if (p == 0) return;
			if (min_row(i)) begin
				if (keys[i] > keys[p]) begin
					swap_pair(i, p);
					climb(p, 1'b0);
				end else climb(i, 1'b1);
			end else begin
				if (keys[i] < keys[p]) begin
					swap_pair(i, p);
					climb(p, 1'b1);
				end else climb(i, 1'b0);
			end
		endfunction

		function void lower_slot(int unsigned i);
			bit want_min;
			int unsigned a, best, x;
			int unsigned cand[6];
			want_min = min_row(i);
			forever begin
				a = 2 * i;
				cand[0] = a; cand[1] = a + 1;
				cand[2] = 2 * a; cand[3] = 2 * a + 1;
				cand[4] = 2 * (a + 1); cand[5] = 2 * (a + 1) + 1;
				best = 0;
				for (int c = 0; c < 6; c++) begin
					x = cand[c];
					if (x <= held && (best == 0 || ahead(x, best, want_min))) best = x;
				end
				if (best == 0) return;
				if (!ahead(best, i, want_min)) return;
				swap_pair(i, best);
				if (best <= a + 1) return;
				if (!ahead(best, best / 2, want_min)) swap_pair(best, best / 2);
				i = best;
			end
		endfunction

		function void take(int unsigned idx, output logic [KEY_W-1:0] k,
				output logic [TAG_W-1:0] t);
			k = keys[idx];
			t = tags[idx];
			keys[idx] = keys[held];
			tags[idx] = tags[held];
			held--;
			if (idx <= held) lower_slot(idx);
		endfunction

		function logic [KEY_W-1:0] top_key();
			if (held == 0) return '0;
			if (held == 1) return keys[1];
			if (held == 2) return keys[2];
			return (keys[2] > keys[3]) ? keys[2] : keys[3];
		endfunction

		// Work out the result of one accepted item and queue it
		function void note_item(in_item_t it);
			out_item_t   r;
			int unsigned eff, idx;
			logic [KEY_W-1:0] k;
			logic [TAG_W-1:0] t;
			eff = (bound_reg < 2 || bound_reg > HEAP_SLOTS) ? HEAP_SLOTS : bound_reg;
			k = '0;
			t = '0;
			if (it.kind == KIND_INSERT) begin
				r.outcome = OUT_INSERTED;
				if (held >= eff) begin
					if (keys[1] > it.key) begin
						r.outcome = OUT_REJECTED;
						k = it.key;
						t = it.tag;
						rejections++;
					end else begin
						r.outcome = OUT_EVICTED;
						take(1, k, t);
						evictions++;
					end
				end
				if (r.outcome != OUT_REJECTED && held < HEAP_SLOTS) begin
					held++;
					keys[held] = it.key;
					tags[held] = it.tag;
					raise_slot(held);
				end
			end else if (held == 0) begin
				r.outcome = OUT_EMPTY;
			end else begin
				r.outcome = OUT_POPPED;
				if (it.kind == KIND_POP_MIN) idx = 1;
				else if (held <= 2) idx = held;
				else idx = (keys[2] < keys[3]) ? 3 : 2;
				take(idx, k, t);
			end
			if (held > max_held) max_held = held;
			r.out_key = k;
			r.out_tag = t;
			r.entry_count = held[CNT_W-1:0];
			r.least_key = (held != 0) ? keys[1] : '0;
			r.greatest_key = top_key();
			pending.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing expected: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.outcome !== want.outcome || got.out_key !== want.out_key ||
					got.out_tag !== want.out_tag || got.entry_count !== want.entry_count ||
					got.least_key !== want.least_key ||
					got.greatest_key !== want.greatest_key) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at result %0d", results_seen);
					$display("  expected %p", want);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_item;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_item;

	heap_scoreboard   sb;
	bit               idle_off;
	int unsigned      items_sent;

	bounded_min_max_heap i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(logic [1:0] kind, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
		int unsigned gap;
		bit          taken;
		in_item_t    it;
		gap = idle_off ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.kind = kind;
		it.key = key;
		it.tag = tag;
		in_valid <= 1'b1;
		in_item <= it;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		sb.note_item(it);
		items_sent++;
	endtask

	// Write the bound once every expected result is back
	task automatic write_bound(logic [CNT_W-1:0] v);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_bound(v);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return KEY_W'($urandom_range(0, 15));
			1: return $urandom_range(0, 1) ? '1 : '0;
			default: return KEY_W'($urandom);
		endcase
	endfunction

	// Random traffic, insert_pct percent of it inserts
	task automatic random_run(int unsigned n, int unsigned insert_pct);
		logic [1:0] kind;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 60 == 0) idle_off = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < insert_pct) kind = KIND_INSERT;
			else case ($urandom_range(0, 4))
				0, 1: kind = KIND_POP_MIN;
				2, 3: kind = KIND_POP_MAX;
				default: kind = KIND_ALT_MAX;
			endcase
			send_item(kind, pick_key(), TAG_W'($urandom));
		end
	endtask

	// Accept results after random stalls and check each one
	initial begin
		int unsigned stall;
		bit          seen;
		out_item_t   got;
		@(posedge arst_n);
		forever begin
			stall = idle_off ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				seen = out_valid;
				got = out_item;
				@(posedge clk);
			end while (!seen);
			sb.check_result(got);
		end
	end

	// Stimulus
	initial begin
		sb = new();
		idle_off = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pops, extremes, equal keys, every kind
		send_item(KIND_POP_MIN, '1, '1);
		send_item(KIND_POP_MAX, '0, '0);
		send_item(KIND_ALT_MAX, '0, '0);
		send_item(KIND_INSERT, '0, '1);
		send_item(KIND_POP_MAX, '0, '0);
		send_item(KIND_INSERT, '1, '0);
		send_item(KIND_INSERT, '0, 16'h5555);
		send_item(KIND_INSERT, 32'd7, 16'haaaa);
		send_item(KIND_INSERT, 32'd7, 16'h1234);
		send_item(KIND_INSERT, 32'h8000_0000, 16'h8000);
		send_item(KIND_INSERT, 32'h7fff_ffff, 16'h0001);
		send_item(KIND_ALT_MAX, '0, '0);
		send_item(KIND_POP_MAX, '0, '0);
		send_item(KIND_POP_MIN, '0, '0);
		send_item(KIND_POP_MIN, '0, '0);
		send_item(KIND_POP_MAX, '0, '0);
		send_item(KIND_POP_MIN, '0, '0);
		send_item(KIND_POP_MIN, '0, '0);

		// Tight bound: full at two, equal-to-minimum insert evicts
		write_bound(9'd2);
		send_item(KIND_INSERT, 32'd10, 16'd1);
		send_item(KIND_INSERT, 32'd20, 16'd2);
		send_item(KIND_INSERT, 32'd10, 16'd3);
		send_item(KIND_INSERT, 32'd9, 16'd4);
		send_item(KIND_INSERT, '1, 16'd5);
		random_run(100, 60);

		// Fill to the full depth, then shrink the bound under the count
		write_bound(9'd256);
		random_run(500, 85);
		write_bound(9'd5);
		random_run(120, 70);
		write_bound(9'd0);
		random_run(150, 40);
		write_bound(9'd1);
		random_run(100, 65);
		write_bound(9'd511);
		random_run(120, 75);
		write_bound(9'd257);
		random_run(80, 50);
		write_bound(CNT_W'($urandom_range(3, 40)));
		random_run(150, 60);
		write_bound(9'd256);
		random_run(100, 30);
		in_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d items sent, %0d results checked, %0d evictions, %0d rejections",
			items_sent, sb.results_seen, sb.evictions, sb.rejections);
		$display("largest heap held %0d entries; bounds 0, 1, 2, 5, 256, 257, 511 used",
			sb.max_held);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("bounded_min_max_heap verification clean");
		else
			$display("bounded_min_max_heap verification failed");
		$finish;
	end

	// Stop a hung run
	initial begin
		#30000000;
		$display("bounded_min_max_heap verification failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/bmmh_pkg.sv
hdl/bmmh_store.sv
hdl/bmmh_ctrl.sv
hdl/bounded_min_max_heap.sv
tb/bounded_min_max_heap_test.sv
